// File: design/shc_pkg.sv
package shc_pkg;

  // Sizes of the block
  localparam int MAX_GROUPS  = 64;
  localparam int WEIGHT_BITS = 24;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int POS_W   = 6;
  localparam int CFG_W   = 7;
  localparam int SCORE_W = 30;

  // Derived widths
  localparam int IDX_W   = $clog2(MAX_GROUPS);
  localparam int CNT_W   = $clog2(MAX_GROUPS + 1);
  localparam int WADDR_W = 2 * IDX_W;
  localparam int WDEPTH  = MAX_GROUPS * MAX_GROUPS;
  localparam int ACC_W   = WEIGHT_BITS + IDX_W;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [CFG_W-1:0]   GROUP_COUNT_RESET = CFG_W'(MAX_GROUPS);

  // Item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_SWAP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_RESET = 2'd3
  } cmd_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic weight_write;
    logic order_reset;
    logic read_capture;
    logic swap_write_a;
    logic swap_write_b;
    logic revert_a;
    logic revert_b;
    logic scan_start;
    logic set_base;
    logic judge;
    logic out_load;
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic known;
    logic swap_ok;
    logic scan_done;
    logic better;
    logic out_free;
  } dp_stat_t;

endpackage

// File: design/swap_hill_climb_path_order.sv
// Pairwise swap hill climber over a group order of n = group_count positions
// (clamped to 2..64). Each command gives one result. The path score is rebuilt
// by a rescan that reads one order entry and one weight per cycle through the
// single read port of the weight memory. A swap with the score already known
// reads both order entries, writes them swapped and rescans; it keeps the swap
// if the score rose and else writes both entries back, and then the result
// goes to the output register. When the score must first be rebuilt (after
// reset, a weight write, an order reset or a group_count write) another rescan
// is added first. A swap with a position out of range changes no entry, after
// any rebuild. Weight writes and order resets always clear the score and are
// followed by a rescan; reads rescan only if the score is not known. A stalled
// output holds the result back for as long as the stall lasts. A new item is
// taken as soon as the previous result is in the output register, not before.
// Weights read before they are written give undefined scores.
module swap_hill_climb_path_order import shc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CMD_W-1:0]       command,
  input  logic [POS_W-1:0]       row_index,
  input  logic [POS_W-1:0]       col_index,
  input  logic [WEIGHT_BITS-1:0] weight,
  input  logic [POS_W-1:0]       pos_a,
  input  logic [POS_W-1:0]       pos_b,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   accepted,
  output logic [SCORE_W-1:0]     score,
  output logic [POS_W-1:0]       group_at_pos
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // Sequencer
  shc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Order, weights, scan and output register
  shc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .command      (command),
    .row_index    (row_index),
    .col_index    (col_index),
    .weight       (weight),
    .pos_a        (pos_a),
    .pos_b        (pos_b),
    .ctrl         (ctrl),
    .stat         (stat),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .accepted     (accepted),
    .score        (score),
    .group_at_pos (group_at_pos)
  );

endmodule

// File: design/shc_ctrl.sv
module shc_ctrl import shc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl
);

  typedef enum logic [11:0] {
    S_IDLE       = 12'b0000_0000_0001,
    S_EXEC       = 12'b0000_0000_0010,
    S_READ_CAP   = 12'b0000_0000_0100,
    S_CHECK      = 12'b0000_0000_1000,
    S_SCAN_BASE  = 12'b0000_0001_0000,
    S_SWAP_RD    = 12'b0000_0010_0000,
    S_SWAP_WA    = 12'b0000_0100_0000,
    S_SWAP_WB    = 12'b0000_1000_0000,
    S_SCAN_FRESH = 12'b0001_0000_0000,
    S_REVERT_A   = 12'b0010_0000_0000,
    S_REVERT_B   = 12'b0100_0000_0000,
    S_DONE       = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.cmd)
          CMD_WRITE: begin
            ctrl.weight_write = 1'b1;
            state_next        = S_CHECK;
          end
          CMD_RESET: begin
            ctrl.order_reset = 1'b1;
            state_next       = S_CHECK;
          end
          CMD_READ: begin
            state_next = S_READ_CAP;
          end
          CMD_SWAP: begin
            if (!stat.known) begin
              ctrl.scan_start = 1'b1;
              state_next      = S_SCAN_BASE;
            end else if (stat.swap_ok) begin
              state_next = S_SWAP_RD;
            end else begin
              state_next = S_DONE;
            end
          end
          default: state_next = S_CHECK;
        endcase
      end
      S_READ_CAP: begin
        ctrl.read_capture = 1'b1;
        state_next        = S_CHECK;
      end
      S_CHECK: begin
        if (stat.known) begin
          state_next = S_DONE;
        end else begin
          ctrl.scan_start = 1'b1;
          state_next      = S_SCAN_BASE;
        end
      end
      S_SCAN_BASE: begin
        if (stat.scan_done) begin
          ctrl.set_base = 1'b1;
          state_next = (stat.cmd == CMD_SWAP && stat.swap_ok) ? S_SWAP_RD : S_DONE;
        end
      end
      S_SWAP_RD: begin
        state_next = S_SWAP_WA;
      end
      S_SWAP_WA: begin
        ctrl.swap_write_a = 1'b1;
        state_next        = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        ctrl.swap_write_b = 1'b1;
        ctrl.scan_start   = 1'b1;
        state_next        = S_SCAN_FRESH;
      end
      S_SCAN_FRESH: begin
        if (stat.scan_done) begin
          if (stat.better) begin
            ctrl.judge = 1'b1;
            state_next = S_DONE;
          end else begin
            state_next = S_REVERT_A;
          end
        end
      end
      S_REVERT_A: begin
        ctrl.revert_a = 1'b1;
        state_next    = S_REVERT_B;
      end
      S_REVERT_B: begin
        ctrl.revert_b = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/shc_dp.sv
module shc_dp import shc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic [CMD_W-1:0]       command,
  input  logic [POS_W-1:0]       row_index,
  input  logic [POS_W-1:0]       col_index,
  input  logic [WEIGHT_BITS-1:0] weight,
  input  logic [POS_W-1:0]       pos_a,
  input  logic [POS_W-1:0]       pos_b,
  input  dp_ctrl_t               ctrl,
  output dp_stat_t               stat,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic                   accepted,
  output logic [SCORE_W-1:0]     score,
  output logic [POS_W-1:0]       group_at_pos
);

  function automatic logic [SCORE_W-1:0] saturate(input logic [ACC_W-1:0] v);
    logic [SCORE_W-1:0] r;
    r = SCORE_W'(v);
    if (ACC_W > SCORE_W && v > ACC_W'(SCORE_MAX)) begin
      r = SCORE_MAX;
    end
    return r;
  endfunction

  // Held item
  cmd_t                   item_cmd;
  logic [POS_W-1:0]       item_row;
  logic [POS_W-1:0]       item_col;
  logic [WEIGHT_BITS-1:0] item_wt;
  logic [POS_W-1:0]       item_pa;
  logic [POS_W-1:0]       item_pb;

  // Config and score state
  logic [CFG_W-1:0]   group_count;
  logic [CNT_W-1:0]   n_act;
  logic [IDX_W-1:0]   n_last;
  logic               known;
  logic [SCORE_W-1:0] best;
  logic               acc_flag;
  logic [IDX_W-1:0]   grp;

  // Order memory, two registered read ports, entries not yet written read as identity
  logic [IDX_W-1:0]      order_mem [MAX_GROUPS];
  logic [MAX_GROUPS-1:0] ord_vld;
  logic [IDX_W-1:0]      a_addr, a_data, a_idx, a_val;
  logic [IDX_W-1:0]      b_addr, b_data, b_idx, b_val;
  logic                  a_vld, b_vld;
  logic                  ow_en;
  logic [IDX_W-1:0]      ow_addr, ow_data;
  logic [IDX_W-1:0]      va_q, vb_q;

  // Weight memory
  logic [WEIGHT_BITS-1:0] weight_mem [WDEPTH];
  logic [WEIGHT_BITS-1:0] w_rdata;
  logic [WADDR_W-1:0]     w_raddr;
  logic                   w_in_range;

  // Scan pipeline
  logic               scan_busy;
  logic               issue_on;
  logic [IDX_W-1:0]   p;
  logic               s1_v, s1_first, s2_v;
  logic [IDX_W-1:0]   g_prev;
  logic [ACC_W-1:0]   acc;
  logic               scan_done;
  logic [SCORE_W-1:0] fresh;
  logic               pa_ok, pb_ok;

  // Active group count, clamped to the legal range
  always_comb begin
    if (CNT_W'(group_count) < CNT_W'(2)) begin
      n_act = CNT_W'(2);
    end else if (CNT_W'(group_count) > CNT_W'(MAX_GROUPS)) begin
      n_act = CNT_W'(MAX_GROUPS);
    end else begin
      n_act = CNT_W'(group_count);
    end
  end
  assign n_last = IDX_W'(n_act - CNT_W'(1));

  assign pa_ok = (CNT_W'(item_pa) < n_act);
  assign pb_ok = (CNT_W'(item_pb) < n_act);

  // Item capture
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      item_cmd <= cmd_t'(command);
      item_row <= row_index;
      item_col <= col_index;
      item_wt  <= weight;
      item_pa  <= pos_a;
      item_pb  <= pos_b;
    end
  end

  // Order read ports
  assign a_addr = scan_busy ? p : IDX_W'(item_pa);
  assign b_addr = IDX_W'(item_pb);

  always_ff @(posedge clk) begin
    a_data <= order_mem[a_addr];
    a_vld  <= ord_vld[a_addr];
    a_idx  <= a_addr;
    b_data <= order_mem[b_addr];
    b_vld  <= ord_vld[b_addr];
    b_idx  <= b_addr;
  end

  assign a_val = a_vld ? a_data : a_idx;
  assign b_val = b_vld ? b_data : b_idx;

  // Order write port: swap, then revert if the score did not rise
  always_comb begin
    ow_en   = ctrl.swap_write_a | ctrl.swap_write_b | ctrl.revert_a | ctrl.revert_b;
    ow_addr = (ctrl.swap_write_a | ctrl.revert_a) ? IDX_W'(item_pa) : IDX_W'(item_pb);
    if (ctrl.swap_write_a) begin
      ow_data = b_val;
    end else if (ctrl.swap_write_b | ctrl.revert_a) begin
      ow_data = va_q;
    end else begin
      ow_data = vb_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ow_en) begin
      order_mem[ow_addr] <= ow_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.order_reset) begin
      ord_vld <= '0;
    end else if (ow_en) begin
      ord_vld[ow_addr] <= 1'b1;
    end
  end

  // Values before the swap, kept for a revert
  always_ff @(posedge clk) begin
    if (ctrl.swap_write_a) begin
      va_q <= a_val;
      vb_q <= b_val;
    end
  end

  // Weight memory
  assign w_in_range = (CNT_W'(item_row) < CNT_W'(MAX_GROUPS)) &&
                      (CNT_W'(item_col) < CNT_W'(MAX_GROUPS));
  assign w_raddr = {g_prev, a_val};

  always_ff @(posedge clk) begin
    if (ctrl.weight_write && w_in_range) begin
      weight_mem[{item_row[IDX_W-1:0], item_col[IDX_W-1:0]}] <= item_wt;
    end
    w_rdata <= weight_mem[w_raddr];
  end

  // Path scan: order read, weight read, accumulate
  assign scan_done = scan_busy && !issue_on && !s1_v && !s2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_busy <= 1'b0;
      issue_on  <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
    end else if (ctrl.scan_start) begin
      scan_busy <= 1'b1;
      issue_on  <= 1'b1;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
    end else begin
      s1_v <= issue_on;
      s2_v <= s1_v && !s1_first;
      if (issue_on && p == n_last) begin
        issue_on <= 1'b0;
      end
      if (scan_done) begin
        scan_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan_start) begin
      p   <= '0;
      acc <= '0;
    end else begin
      if (issue_on) begin
        p <= p + IDX_W'(1);
      end
      if (s2_v) begin
        acc <= acc + ACC_W'(w_rdata);
      end
    end
    s1_first <= (p == '0);
    if (s1_v) begin
      g_prev <= a_val;
    end
  end

  assign fresh = saturate(acc);

  // Config, score and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= GROUP_COUNT_RESET;
      known       <= 1'b0;
      best        <= '0;
    end else begin
      if (cfg_wen) begin
        group_count <= cfg_wdata;
      end
      if (cfg_wen || ctrl.weight_write || ctrl.order_reset) begin
        known <= 1'b0;
      end else if (ctrl.set_base) begin
        known <= 1'b1;
      end
      if (ctrl.set_base || ctrl.judge) begin
        best <= fresh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      acc_flag <= 1'b0;
      grp      <= '0;
    end else begin
      if (ctrl.judge) begin
        acc_flag <= 1'b1;
      end
      if (ctrl.read_capture) begin
        grp <= pa_ok ? a_val : '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      accepted     <= acc_flag;
      score        <= best;
      group_at_pos <= POS_W'(grp);
    end
  end

  // Status
  always_comb begin
    stat.cmd       = item_cmd;
    stat.known     = known;
    stat.swap_ok   = pa_ok && pb_ok;
    stat.scan_done = scan_done;
    stat.better    = (fresh > best);
    stat.out_free  = !out_valid || !out_stall;
  end

endmodule
